/* rtl/vsog_pkg.sv */
// Shared types and constants for the voxel sphere occupancy grid.
// Used by the front, the command queue, the back and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vsog_pkg;

    localparam int COORD_W   = 16;
    localparam int CFG_W     = 12;
    localparam int RAD_W     = 4;
    localparam int LIM_W     = 3;
    localparam int SNAP_W    = 18;
    localparam int SQ_W      = 24;
    localparam int OFF_W     = 4;
    localparam int OUT_CNT_W = 8;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_GRID_STEP    = 2'd0;
    localparam logic [1:0] REG_CUTOFF_DIST  = 2'd1;
    localparam logic [1:0] REG_STAMP_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0] GRID_STEP_RST    = 12'd32;
    localparam logic [CFG_W-1:0] CUTOFF_DIST_RST  = 12'd170;
    localparam logic [RAD_W-1:0] STAMP_RADIUS_RST = 4'd6;

    typedef struct packed {
        logic                     op;
        logic signed [SNAP_W-1:0] sx;
        logic signed [SNAP_W-1:0] sy;
        logic signed [SNAP_W-1:0] sz;
        logic [SQ_W-1:0]          g2;
        logic [SQ_W-1:0]          c2;
        logic [LIM_W-1:0]         lim;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ROUND,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EVAL,
        B_STAMP,
        B_QUERY,
        B_QDATA,
        B_FINISH
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/vsog_front.sv */
// Front end: accepts a transaction, snaps the point to a cell with a
// bit-serial divider per axis and builds a command. Depends on vsog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsog_front #(
    parameter int MAX_RADIUS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic signed [15:0]            coord_x,
    input  logic signed [15:0]            coord_y,
    input  logic signed [15:0]            coord_z,
    input  logic [11:0]                   grid_step,
    input  logic [11:0]                   cutoff_dist,
    input  logic [3:0]                    stamp_radius,
    input  logic                          clear_busy,
    output vsog_pkg::cmd_t                cmd,
    output logic                          cmd_push,
    input  logic                          cmd_full
);
    import vsog_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    front_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [COORD_W-1:0] mag_reg [3];
    logic [CFG_W-1:0] rem_reg [3];
    logic [COORD_W-1:0] quo_reg [3];
    logic neg_reg [3];
    logic op_reg;
    logic [CFG_W-1:0] g_reg;
    logic [CFG_W-1:0] cut_reg;
    logic [LIM_W-1:0] lim_reg;
    cmd_t cmd_reg;

    logic signed [COORD_W-1:0] coord_in [3];
    logic [CFG_W:0] rem_sh [3];
    logic quo_bit [3];
    logic [CFG_W-1:0] rem_new [3];
    logic signed [SNAP_W-1:0] snap_val [3];
    logic [RAD_W-1:0] rad_c;
    logic accept;
    logic [SQ_W-1:0] g2;
    logic [SQ_W-1:0] c2;

    assign coord_in[0] = coord_x;
    assign coord_in[1] = coord_y;
    assign coord_in[2] = coord_z;
    assign accept = push && !full;
    assign cmd = cmd_reg;
    assign g2 = g_reg * g_reg;
    assign c2 = cut_reg * cut_reg;

    always_comb
    begin
        if (stamp_radius == '0)
            rad_c = RAD_W'(1);
        else if (stamp_radius > RAD_W'(MAX_RADIUS))
            rad_c = RAD_W'(MAX_RADIUS);
        else
            rad_c = stamp_radius;
    end

    // One quotient bit per cycle on each axis, restoring form.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [COORD_W:0] qr;
            logic up;
            rem_sh[i] = {rem_reg[i], mag_reg[i][COORD_W-1]};
            quo_bit[i] = rem_sh[i] >= {1'b0, g_reg};
            rem_new[i] = quo_bit[i] ? CFG_W'(rem_sh[i] - {1'b0, g_reg})
                                    : rem_sh[i][CFG_W-1:0];
            up = {rem_reg[i], 1'b0} >= {1'b0, g_reg};
            qr = {1'b0, quo_reg[i]} + {{COORD_W{1'b0}}, up};
            snap_val[i] = neg_reg[i] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(COORD_W - 1))
                    state_next = F_ROUND;
            end
            F_ROUND:
                state_next = F_PUSH;
            F_PUSH:
            begin
                if (!cmd_full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full = (state_reg != F_IDLE) || clear_busy;
        cmd_push = (state_reg == F_PUSH) && !cmd_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= opcode;
            g_reg <= (grid_step == '0) ? CFG_W'(1) : grid_step;
            cut_reg <= cutoff_dist;
            lim_reg <= LIM_W'(rad_c - RAD_W'(1));
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= coord_in[i][COORD_W-1];
                mag_reg[i] <= coord_in[i][COORD_W-1] ? COORD_W'(-coord_in[i])
                                                     : COORD_W'(coord_in[i]);
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
        end
        else if (state_reg == F_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= {mag_reg[i][COORD_W-2:0], 1'b0};
                rem_reg[i] <= rem_new[i];
                quo_reg[i] <= {quo_reg[i][COORD_W-2:0], quo_bit[i]};
            end
        end
        if (state_reg == F_ROUND)
        begin
            cmd_reg.op <= op_reg;
            cmd_reg.sx <= snap_val[0];
            cmd_reg.sy <= snap_val[1];
            cmd_reg.sz <= snap_val[2];
            cmd_reg.g2 <= g2;
            cmd_reg.c2 <= c2;
            cmd_reg.lim <= lim_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/vsog_cmd_queue.sv */
// Two-entry command queue between the front and the back.
// Depends on vsog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsog_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  vsog_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output vsog_pkg::cmd_t rd_data,
    output logic           q_empty
);
    import vsog_pkg::*;

    cmd_t q_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign q_full = cnt_reg == 2'd2;
    assign q_empty = cnt_reg == 2'd0;
    assign rd_data = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* rtl/vsog_back.sv */
// Back end: owns the cell counter memory, clears it after reset, walks the
// stamp cube for adds and reads the cell for queries. Depends on vsog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsog_back #(
    parameter int GRID_DIM   = 64,
    parameter int COUNT_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  vsog_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output logic           clear_busy,
    output logic           empty,
    input  logic           pop,
    output logic           op_done,
    output logic           occupied,
    output logic [7:0]     cell_count,
    output logic           out_of_range
);
    import vsog_pkg::*;

    localparam int HALF   = GRID_DIM / 2;
    localparam int AXW    = $clog2(GRID_DIM);
    localparam int CELLS  = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = SNAP_W + 1;
    localparam int CXW    = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
    localparam logic signed [CELL_W-1:0] LO = CELL_W'(-HALF);
    localparam logic signed [CELL_W-1:0] HI = CELL_W'(HALF - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    back_state_t state_reg, state_next;
    cmd_t cmd_reg;
    logic signed [OFF_W-1:0] off_reg [3];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic oor_reg;
    logic q_in_reg;
    logic res_valid_reg;
    logic res_op_reg;
    logic res_occ_reg;
    logic [OUT_CNT_W-1:0] res_cnt_reg;
    logic res_oor_reg;
    logic [COUNT_BITS-1:0] mem [CELLS];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic signed [CELL_W-1:0] cell_pos [3];
    logic signed [SNAP_W-1:0] base [3];
    logic [CELL_W-1:0] shifted [3];
    logic [AXW-1:0] idx [3];
    logic [OUT_CNT_W-1:0] sq [3];
    logic [OUT_CNT_W-1:0] d2;
    logic [31:0] prod;
    logic stamp;
    logic in_ws;
    logic last;
    logic advance;
    logic [ADDR_W-1:0] cell_addr;
    logic signed [OFF_W-1:0] lim_s;
    logic signed [OFF_W-1:0] new_lim_s;
    logic rd_en;
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [CXW-1:0] rd_ext;

    assign base[0] = cmd_reg.sx;
    assign base[1] = cmd_reg.sy;
    assign base[2] = cmd_reg.sz;
    assign lim_s = $signed({1'b0, cmd_reg.lim});
    assign new_lim_s = $signed({1'b0, cmd.lim});

    always_comb
    begin
        in_ws = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [7:0] d8;
            cell_pos[i] = CELL_W'(base[i]) + CELL_W'(off_reg[i]);
            shifted[i] = cell_pos[i] - LO;
            idx[i] = shifted[i][AXW-1:0];
            d8 = 8'(off_reg[i]);
            sq[i] = 8'(d8 * d8);
            if (cell_pos[i] < LO || cell_pos[i] > HI)
                in_ws = 1'b0;
        end
        d2 = sq[0] + sq[1] + sq[2];
        prod = d2 * cmd_reg.g2;
        stamp = prod < 32'(cmd_reg.c2);
        cell_addr = ADDR_W'(idx[2]) * ADDR_W'(GRID_DIM * GRID_DIM)
                  + ADDR_W'(idx[1]) * ADDR_W'(GRID_DIM) + ADDR_W'(idx[0]);
        last = off_reg[0] == lim_s && off_reg[1] == lim_s && off_reg[2] == lim_s;
        rd_ext = CXW'(rd_data_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!cmd_empty && !res_valid_reg)
                    state_next = (cmd.op == OP_QUERY) ? B_QUERY : B_EVAL;
            end
            B_EVAL:
            begin
                if (stamp && in_ws)
                    state_next = B_STAMP;
                else if (last)
                    state_next = B_FINISH;
            end
            B_STAMP:
                state_next = last ? B_FINISH : B_EVAL;
            B_QUERY:
                state_next = B_QDATA;
            B_QDATA:
                state_next = B_IDLE;
            B_FINISH:
                state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop = (state_reg == B_IDLE) && !cmd_empty && !res_valid_reg;
        clear_busy = state_reg == B_CLEAR;
        rd_en = ((state_reg == B_EVAL) && stamp && in_ws)
             || ((state_reg == B_QUERY) && in_ws);
        wr_en = (state_reg == B_CLEAR) || (state_reg == B_STAMP);
        wr_addr = (state_reg == B_CLEAR) ? clr_cnt_reg : addr_reg;
        if (state_reg == B_CLEAR)
            wr_data = '0;
        else if (rd_data_reg == COUNT_MAX)
            wr_data = rd_data_reg;
        else
            wr_data = rd_data_reg + COUNT_BITS'(1);
        advance = ((state_reg == B_EVAL) && !(stamp && in_ws)) || (state_reg == B_STAMP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_cnt_reg <= '0;
            res_valid_reg <= 1'b0;
            oor_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                off_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (state_reg == B_QDATA || state_reg == B_FINISH)
                res_valid_reg <= 1'b1;
            else if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            if (cmd_pop)
                oor_reg <= 1'b0;
            else if (state_reg == B_EVAL && stamp && !in_ws)
                oor_reg <= 1'b1;
            if (cmd_pop && cmd.op == OP_ADD)
            begin
                for (int i = 0; i < 3; i++)
                    off_reg[i] <= -new_lim_s;
            end
            else if (advance)
            begin
                // Walk z fastest, then y, then x; return to zero at the end.
                if (last)
                begin
                    for (int i = 0; i < 3; i++)
                        off_reg[i] <= '0;
                end
                else if (off_reg[2] != lim_s)
                    off_reg[2] <= off_reg[2] + OFF_W'(1);
                else
                begin
                    off_reg[2] <= -lim_s;
                    if (off_reg[1] != lim_s)
                        off_reg[1] <= off_reg[1] + OFF_W'(1);
                    else
                    begin
                        off_reg[1] <= -lim_s;
                        off_reg[0] <= off_reg[0] + OFF_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd;
        if (state_reg == B_EVAL)
            addr_reg <= cell_addr;
        if (state_reg == B_QUERY)
            q_in_reg <= in_ws;
        if (state_reg == B_QDATA)
        begin
            res_op_reg <= OP_QUERY;
            res_occ_reg <= q_in_reg && (rd_data_reg != '0);
            if (!q_in_reg)
                res_cnt_reg <= '0;
            else if (rd_ext > CXW'(255))
                res_cnt_reg <= 8'hFF;
            else
                res_cnt_reg <= rd_ext[OUT_CNT_W-1:0];
            res_oor_reg <= !q_in_reg;
        end
        else if (state_reg == B_FINISH)
        begin
            res_op_reg <= OP_ADD;
            res_occ_reg <= 1'b0;
            res_cnt_reg <= '0;
            res_oor_reg <= oor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[cell_addr];
    end

    assign empty = !res_valid_reg;
    assign op_done = res_op_reg;
    assign occupied = res_occ_reg;
    assign cell_count = res_cnt_reg;
    assign out_of_range = res_oor_reg;

endmodule

`default_nettype wire

/* rtl/voxel_sphere_occupancy_grid.sv */
// Flow: the front snaps each point with a bit-serial divider per axis, then a
// rounding state, then a queue write; a query then passes the back's query and
// query-data states, while an add evaluates every candidate offset, stamps each cell
// that passes and finishes, over (2*(r-1)+1)^3 candidates, r being stamp_radius clamped to 1..MAX_RADIUS.
// The front takes no new transaction until it has pushed the last one, while the back
// works one at a time. After reset all GRID_DIM^3 counter cells are cleared, with full high.
`timescale 1ns / 1ps
`default_nettype none

module voxel_sphere_occupancy_grid #(
    parameter int GRID_DIM   = 64,
    parameter int COUNT_BITS = 8,
    parameter int MAX_RADIUS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic signed [15:0]                  coord_x,
    input  logic signed [15:0]                  coord_y,
    input  logic signed [15:0]                  coord_z,
    output logic                                empty,
    input  logic                                pop,
    output logic                                op_done,
    output logic                                occupied,
    output logic [7:0]                          cell_count,
    output logic                                out_of_range,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vsog_pkg::PADDR_W-1:0]        paddr,
    input  logic [vsog_pkg::DATA_W-1:0]         pwdata,
    output logic [vsog_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import vsog_pkg::*;

    logic [CFG_W-1:0] grid_step_reg;
    logic [CFG_W-1:0] cutoff_dist_reg;
    logic [RAD_W-1:0] stamp_radius_reg;
    logic cfg_wr;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    logic clear_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_step_reg <= GRID_STEP_RST;
            cutoff_dist_reg <= CUTOFF_DIST_RST;
            stamp_radius_reg <= STAMP_RADIUS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GRID_STEP:    grid_step_reg <= pwdata[CFG_W-1:0];
                REG_CUTOFF_DIST:  cutoff_dist_reg <= pwdata[CFG_W-1:0];
                REG_STAMP_RADIUS: stamp_radius_reg <= pwdata[RAD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRID_STEP:    prdata = DATA_W'(grid_step_reg);
            REG_CUTOFF_DIST:  prdata = DATA_W'(cutoff_dist_reg);
            REG_STAMP_RADIUS: prdata = DATA_W'(stamp_radius_reg);
            default:          prdata = '0;
        endcase
    end

    vsog_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .opcode(opcode),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .coord_z(coord_z),
        .grid_step(grid_step_reg),
        .cutoff_dist(cutoff_dist_reg),
        .stamp_radius(stamp_radius_reg),
        .clear_busy(clear_busy),
        .cmd(front_cmd),
        .cmd_push(cmd_push),
        .cmd_full(cmd_full)
    );

    vsog_cmd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(cmd_push),
        .wr_data(front_cmd),
        .q_full(cmd_full),
        .rd_en(cmd_pop),
        .rd_data(queue_cmd),
        .q_empty(cmd_empty)
    );

    vsog_back #(
        .GRID_DIM(GRID_DIM),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(queue_cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop(cmd_pop),
        .clear_busy(clear_busy),
        .empty(empty),
        .pop(pop),
        .op_done(op_done),
        .occupied(occupied),
        .cell_count(cell_count),
        .out_of_range(out_of_range)
    );

endmodule

`default_nettype wire
